// ===== src/fsg_pkg.sv =====
// Package for the falling-sand grid block: kinds, actions, FSM states, constants.
// No dependencies.
package fsg_pkg;

  localparam int unsigned DEF_GRID_W     = 64;
  localparam int unsigned DEF_GRID_H     = 64;
  localparam int unsigned DEF_MAX_RADIUS = 15;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] SEED_RESET = 16'd1;

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_DISC = 2'd1,
    ACT_READ = 2'd2,
    ACT_TICK = 2'd3
  } action_t;

  localparam logic [2:0] KIND_EMPTY = 3'd0;
  localparam logic [2:0] KIND_SAND  = 3'd1;
  localparam logic [2:0] KIND_WATER = 3'd2;
  localparam logic [2:0] KIND_STONE = 3'd3;
  localparam logic [2:0] KIND_GAS   = 3'd4;
  localparam logic [2:0] KIND_DIRT  = 3'd5;

  localparam logic [1:0] REG_RANDOM_SEED = 2'd0;

  typedef enum logic [3:0] {
    ST_CLEAR,      // sweep memories after reset
    ST_IDLE,
    ST_READ_WAIT,  // dispatch on the loaded action
    ST_READ_DONE,
    ST_DISC,       // one disc cell per cycle
    ST_MCLR,       // clear marks before tick
    ST_T_MARK,     // read mark of current cell
    ST_T_HERE,     // read current cell
    ST_T_NB,       // read a neighbor
    ST_T_NB_EVAL,
    ST_T_WR_THERE, // write moved-in cell
    ST_T_WR_HERE,  // write current cell and advance
    ST_RESULT
  } state_t;

  // Neighbor probe order: down, down-left, down-right, right, left.
  typedef enum logic [2:0] {
    NB_D  = 3'd0,
    NB_DL = 3'd1,
    NB_DR = 3'd2,
    NB_R  = 3'd3,
    NB_L  = 3'd4
  } nb_t;

  function automatic logic [1:0] kind_density(input logic [2:0] k);
    case (k)
      KIND_SAND:  kind_density = 2'd2;
      KIND_WATER: kind_density = 2'd1;
      KIND_STONE: kind_density = 2'd3;
      KIND_DIRT:  kind_density = 2'd2;
      default:    kind_density = 2'd0;
    endcase
  endfunction

  function automatic logic kind_falls(input logic [2:0] k);
    kind_falls = (k == KIND_SAND) || (k == KIND_WATER) || (k == KIND_DIRT);
  endfunction

  function automatic logic kind_flows(input logic [2:0] k);
    kind_flows = (k == KIND_WATER);
  endfunction

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;
    logic clr_start;
    logic clr_step;
    logic disc_start;
    logic disc_step;
    logic scan_start;
    logic scan_step;
    logic nb_load;
    logic nb_next;
    logic nb_eval;
    logic rd_here;
    logic rd_mark;
    logic rd_target;
    logic rd_nb;
    logic wr_there;
    logic wr_here;
    logic wr_set;
    logic wr_clear_cell;
    logic wr_clear_mark;
    logic result_load;
  } fsg_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    action_t action;
    logic    clr_last;
    logic    disc_last;
    logic    scan_last;
    logic    marked;
    logic    nb_done;
    logic    moved;
  } fsg_sts_t;

endpackage

// ===== src/fsg_if.sv =====
// Valid/ready channel interface used by both sides of the block.
// Depends on nothing; payload width given by parameter.
interface fsg_if #(
  parameter int unsigned W = 8
) (
  input logic clk
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/fsg_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module fsg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== src/fsg_datapath.sv =====
// Datapath: item registers, cell and mark memories, counters, LFSR, result.
// Depends on fsg_pkg and fsg_ram.
module fsg_datapath
  import fsg_pkg::*;
#(
  parameter int unsigned GRID_W     = DEF_GRID_W,
  parameter int unsigned GRID_H     = DEF_GRID_H,
  parameter int unsigned MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic        clk,
  input  logic        rst,
  input  fsg_cmd_t    cmd,
  output fsg_sts_t    sts,
  input  logic [1:0]  in_action,
  input  logic [5:0]  in_x,
  input  logic [5:0]  in_y,
  input  logic [3:0]  in_r,
  input  logic [2:0]  in_kind,
  input  logic        seed_we,
  input  logic [15:0] seed_val,
  output logic [2:0]  read_kind
);
  localparam int unsigned CELLS = GRID_W * GRID_H;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned XW    = $clog2(GRID_W);
  localparam int unsigned YW    = $clog2(GRID_H);
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
  // signed coordinate width covering grid plus disc offsets
  localparam int unsigned CW    = ((XW > YW) ? XW : YW) + 3;
  localparam int unsigned SW    = 2 * RW + 2;

  // item registers
  action_t          action;
  logic [5:0]       ix, iy;
  logic [RW-1:0]    rad;
  logic [2:0]       kind;

  // counters
  logic [AW:0]      clr_cnt;
  logic [XW-1:0]    sx;
  logic [YW-1:0]    sy;
  logic signed [RW+1:0] dx, dy;
  nb_t              nb;
  logic [2:0]       here_kind;
  logic             nb_ok_d, nb_ok_dl, nb_ok_dr, nb_ok_r, nb_ok_l;
  logic             moved;
  logic [XW-1:0]    tx;
  logic [YW-1:0]    ty;
  logic [2:0]       there_kind;
  logic [15:0]      lfsr;

  // memory ports
  logic             cell_we, mark_we;
  logic [AW-1:0]    cell_addr, mark_addr;
  logic [2:0]       cell_wdata, cell_rdata;
  logic             mark_wdata, mark_rdata;

  fsg_ram #(.WIDTH(3), .DEPTH(CELLS)) u_cells (
    .clk(clk), .we(cell_we), .addr(cell_addr), .wdata(cell_wdata), .rdata(cell_rdata)
  );
  fsg_ram #(.WIDTH(1), .DEPTH(CELLS)) u_marks (
    .clk(clk), .we(mark_we), .addr(mark_addr), .wdata(mark_wdata), .rdata(mark_rdata)
  );

  function automatic logic [AW-1:0] idx(input logic [XW-1:0] x, input logic [YW-1:0] y);
    idx = AW'(y) * AW'(GRID_W) + AW'(x);
  endfunction

  // input position in grid
  logic in_ok;
  assign in_ok = (32'(ix) < GRID_W) && (32'(iy) < GRID_H);

  // disc cell coordinates
  logic signed [CW-1:0] px, py;
  logic [SW-1:0] dist2, rad2;
  logic disc_hit;
  assign px = $signed(CW'(ix)) + CW'(dx);
  assign py = $signed(CW'(iy)) + CW'(dy);
  assign dist2 = SW'(dx * dx) + SW'(dy * dy);
  assign rad2  = SW'(rad) * SW'(rad);
  assign disc_hit = (dist2 <= rad2) && (px >= 0) && (py >= 0) &&
                    (px < $signed(CW'(GRID_W))) && (py < $signed(CW'(GRID_H)));

  // neighbor coordinates for current probe
  logic [XW-1:0] nbx;
  logic [YW-1:0] nby;
  logic          nb_in;
  always_comb begin
    nbx   = sx;
    nby   = sy;
    nb_in = 1'b1;
    case (nb)
      NB_D: begin
        nby   = sy + 1'b1;
        nb_in = 32'(sy) < GRID_H - 1;
      end
      NB_DL: begin
        nby   = sy + 1'b1;
        nbx   = sx - 1'b1;
        nb_in = (32'(sy) < GRID_H - 1) && (sx != '0);
      end
      NB_DR: begin
        nby   = sy + 1'b1;
        nbx   = sx + 1'b1;
        nb_in = (32'(sy) < GRID_H - 1) && (32'(sx) < GRID_W - 1);
      end
      NB_R: begin
        nbx   = sx + 1'b1;
        nb_in = 32'(sx) < GRID_W - 1;
      end
      NB_L: begin
        nbx   = sx - 1'b1;
        nb_in = sx != '0;
      end
      default: nb_in = 1'b0;
    endcase
  end

  logic nb_free;
  assign nb_free = nb_in && (kind_density(cell_rdata) < kind_density(here_kind));

  // move decision after all probes of a group are in
  logic       dec_move;
  logic [XW-1:0] dec_tx;
  logic [YW-1:0] dec_ty;
  logic       use_lfsr;
  always_comb begin
    dec_move = 1'b0;
    dec_tx   = sx;
    dec_ty   = sy;
    use_lfsr = 1'b0;
    if (kind_falls(here_kind) && nb_ok_d) begin
      dec_move = 1'b1;
      dec_ty   = sy + 1'b1;
    end else if (kind_falls(here_kind) && (nb_ok_dl || nb_ok_dr)) begin
      dec_move = 1'b1;
      dec_ty   = sy + 1'b1;
      if (nb_ok_dl && nb_ok_dr) begin
        use_lfsr = 1'b1;
        dec_tx   = lfsr[0] ? sx + 1'b1 : sx - 1'b1;
      end else begin
        dec_tx   = nb_ok_dl ? sx - 1'b1 : sx + 1'b1;
      end
    end else if (kind_flows(here_kind) && (nb_ok_r || nb_ok_l)) begin
      dec_move = 1'b1;
      if (nb_ok_r && nb_ok_l) begin
        use_lfsr = 1'b1;
        dec_tx   = lfsr[0] ? sx - 1'b1 : sx + 1'b1;
      end else begin
        dec_tx   = nb_ok_r ? sx + 1'b1 : sx - 1'b1;
      end
    end
  end

  // memory address/write mux
  always_comb begin
    cell_we    = 1'b0;
    mark_we    = 1'b0;
    cell_addr  = idx(sx, sy);
    mark_addr  = idx(sx, sy);
    cell_wdata = KIND_EMPTY;
    mark_wdata = 1'b0;
    if (cmd.wr_clear_cell) begin
      cell_we   = 1'b1;
      cell_addr = clr_cnt[AW-1:0];
    end
    if (cmd.wr_clear_mark) begin
      mark_we   = 1'b1;
      mark_addr = clr_cnt[AW-1:0];
    end
    if (cmd.rd_target) begin
      cell_addr = idx(XW'(ix), YW'(iy));
    end
    if (cmd.wr_set) begin
      cell_we    = 1'b1;
      cell_wdata = kind;
      if (action == ACT_DISC) begin
        cell_we   = disc_hit;
        cell_addr = idx(XW'(px), YW'(py));
      end else begin
        cell_we   = in_ok;
        cell_addr = idx(XW'(ix), YW'(iy));
      end
    end
    if (cmd.rd_nb) begin
      cell_addr = idx(nbx, nby);
    end
    // read the move target so its kind is on the port for the swap
    if (cmd.nb_eval) begin
      cell_addr = idx(dec_tx, dec_ty);
    end
    if (cmd.wr_there) begin
      cell_we    = 1'b1;
      cell_addr  = idx(tx, ty);
      cell_wdata = here_kind;
      mark_we    = 1'b1;
      mark_addr  = idx(tx, ty);
      mark_wdata = 1'b1;
    end
    if (cmd.wr_here) begin
      cell_we    = moved;
      cell_wdata = there_kind;
      mark_we    = 1'b1;
      mark_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action <= action_t'(in_action);
      ix     <= in_x;
      iy     <= in_y;
      rad    <= (32'(in_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(in_r);
      kind   <= (in_kind <= KIND_DIRT) ? in_kind : KIND_EMPTY;
    end
    if (cmd.rd_here) begin
      here_kind <= cell_rdata;
    end
  end

  // scan, disc, clear counters; neighbor state, move target and result
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      sx <= '0;
      sy <= '0;
      dx <= '0;
      dy <= '0;
      nb <= NB_D;
      moved <= 1'b0;
      read_kind <= KIND_EMPTY;
    end else begin
      if (cmd.clr_start) begin
        clr_cnt <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.disc_start) begin
        dx <= -$signed({2'b0, rad});
        dy <= -$signed({2'b0, rad});
      end else if (cmd.disc_step) begin
        if (dx == $signed({2'b0, rad})) begin
          dx <= -$signed({2'b0, rad});
          dy <= dy + 1'b1;
        end else begin
          dx <= dx + 1'b1;
        end
      end
      if (cmd.scan_start) begin
        sx <= '0;
        sy <= '0;
      end else if (cmd.scan_step) begin
        if (32'(sx) == GRID_W - 1) begin
          sx <= '0;
          sy <= sy + 1'b1;
        end else begin
          sx <= sx + 1'b1;
        end
      end
      if (cmd.nb_load) begin
        nb <= kind_falls(cell_rdata) ? NB_D : NB_R;
        nb_ok_d <= 1'b0; nb_ok_dl <= 1'b0; nb_ok_dr <= 1'b0;
        nb_ok_r <= 1'b0; nb_ok_l <= 1'b0;
        moved <= 1'b0;
      end else if (cmd.nb_next) begin
        case (nb)
          NB_D:  nb_ok_d  <= nb_free;
          NB_DL: nb_ok_dl <= nb_free;
          NB_DR: nb_ok_dr <= nb_free;
          NB_R:  nb_ok_r  <= nb_free;
          NB_L:  nb_ok_l  <= nb_free;
          default: ;
        endcase
        nb <= nb_t'(nb + 1'b1);
      end
      if (cmd.nb_eval) begin
        moved <= dec_move;
        tx    <= dec_tx;
        ty    <= dec_ty;
      end
      if (cmd.rd_nb && cmd.nb_eval) begin
        there_kind <= KIND_EMPTY;
      end
      if (cmd.wr_there) begin
        there_kind <= cell_rdata;
      end
      if (cmd.result_load) begin
        read_kind <= (action == ACT_READ && in_ok) ? cell_rdata : KIND_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= SEED_RESET;
    end else if (seed_we) begin
      lfsr <= (seed_val == '0) ? SEED_RESET : seed_val;
    end else if (cmd.nb_eval && use_lfsr) begin
      lfsr <= lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
    end
  end

  // Probes end on a settled fall, a non-flowing kind at NB_R, or after NB_L.
  logic fall_found;
  assign fall_found = (nb == NB_R) && (nb_ok_d || nb_ok_dl || nb_ok_dr);

  assign sts.action    = action;
  assign sts.clr_last  = (clr_cnt == (AW+1)'(CELLS - 1));
  assign sts.disc_last = (dx == $signed({2'b0, rad})) && (dy == $signed({2'b0, rad}));
  assign sts.scan_last = (32'(sx) == GRID_W - 1) && (32'(sy) == GRID_H - 1);
  assign sts.marked    = mark_rdata;
  assign sts.nb_done   = (nb == NB_R && !kind_flows(here_kind)) || fall_found ||
                         (nb > NB_L);
  assign sts.moved     = moved;
endmodule

// ===== src/fsg_ctrl.sv =====
// Controller state machine sequencing clear, set, disc, read and tick work.
// Depends on fsg_pkg.
module fsg_ctrl
  import fsg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  fsg_sts_t sts,
  output fsg_cmd_t cmd
);
  state_t state, state_next;
  logic   out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  assign out_valid = out_full;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    out_full_next = out_full && !out_ready;
    case (state)
      ST_CLEAR: begin
        cmd.wr_clear_cell = 1'b1;
        cmd.wr_clear_mark = 1'b1;
        cmd.clr_step      = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_READ_WAIT;
        end
      end
      ST_READ_WAIT: begin
        case (sts.action)
          ACT_SET: begin
            cmd.wr_set = 1'b1;
            state_next = ST_RESULT;
          end
          ACT_DISC: begin
            cmd.disc_start = 1'b1;
            state_next     = ST_DISC;
          end
          ACT_READ: begin
            cmd.rd_target = 1'b1;
            state_next    = ST_READ_DONE;
          end
          default: begin
            cmd.clr_start = 1'b1;
            state_next    = ST_MCLR;
          end
        endcase
      end
      ST_READ_DONE: begin
        // keep the target addressed so its kind stays on the read port
        cmd.rd_target = 1'b1;
        state_next    = ST_RESULT;
      end
      ST_DISC: begin
        cmd.wr_set    = 1'b1;
        cmd.disc_step = 1'b1;
        if (sts.disc_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_MCLR: begin
        cmd.wr_clear_mark = 1'b1;
        cmd.clr_step      = 1'b1;
        if (sts.clr_last) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_T_MARK;
        end
      end
      ST_T_MARK: begin
        // address = current cell; mark and kind land next cycle
        state_next = ST_T_HERE;
      end
      ST_T_HERE: begin
        cmd.rd_here = 1'b1;
        cmd.nb_load = 1'b1;
        if (sts.marked) begin
          cmd.scan_step = 1'b1;
          state_next    = sts.scan_last ? ST_RESULT : ST_T_MARK;
        end else begin
          state_next = ST_T_NB;
        end
      end
      ST_T_NB: begin
        cmd.rd_nb = 1'b1;
        if (sts.nb_done) begin
          cmd.nb_eval = 1'b1;
          state_next  = ST_T_WR_THERE;
        end else begin
          state_next = ST_T_NB_EVAL;
        end
      end
      ST_T_NB_EVAL: begin
        cmd.rd_nb   = 1'b1;
        cmd.nb_next = 1'b1;
        state_next  = ST_T_NB;
      end
      ST_T_WR_THERE: begin
        // when moved, capture the in-flight target kind and write the mover there
        state_next = sts.moved ? ST_T_WR_HERE : ST_T_WR_HERE;
        if (sts.moved) begin
          cmd.wr_there = 1'b1;
        end
      end
      ST_T_WR_HERE: begin
        cmd.wr_here   = 1'b1;
        cmd.scan_step = 1'b1;
        state_next    = sts.scan_last ? ST_RESULT : ST_T_MARK;
      end
      ST_RESULT: begin
        cmd.rd_target = 1'b1;
        if (!out_full || out_ready) begin
          cmd.result_load = 1'b1;
          out_full_next   = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule

// ===== src/falling_sand_grid_step.sv =====
// Top level of the falling-sand grid block: channels, APB seed register.
// Depends on fsg_pkg, fsg_if, fsg_ctrl, fsg_datapath, fsg_ram.
//
// Usage:
//   req  (sink) carries one request: action, x_pos, y_pos, disc_radius,
//        new_kind. Accepted when req.valid and req.ready are high.
//   rsp  (source) returns one read_kind per request, in order.
//   APB  writes random_seed (address 0); reads return it.
// A tick first clears every mark, then visits each cell in turn: a marked
// cell is skipped; otherwise a falling kind reads the cells below, and water
// that cannot fall looks sideways, one neighbor read at a time; then the
// cell moves or stays, and it and any target are marked.
// One request is worked at a time. After reset a clearing pass empties the
// cell and mark memories; no request is taken then. The result sits in an
// output register: when the receiver stalls, hold it; the next request is
// still taken and worked, and its result waits until the register frees,
// which holds off further requests.
module falling_sand_grid_step
  import fsg_pkg::*;
#(
  parameter int unsigned GRID_W     = DEF_GRID_W,
  parameter int unsigned GRID_H     = DEF_GRID_H,
  parameter int unsigned MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic        clk,
  input  logic        rst,
  fsg_if.sink         req,
  fsg_if.source       rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  fsg_cmd_t    cmd;
  fsg_sts_t    sts;
  logic [15:0] random_seed;
  logic        seed_we;
  logic        ctrl_in_ready;
  logic [2:0]  read_kind;

  // APB: single register at address 0; other addresses are dropped.
  assign pready  = 1'b1;
  assign seed_we = psel && penable && pwrite && (paddr == REG_RANDOM_SEED);
  assign prdata  = (paddr == REG_RANDOM_SEED) ? {16'd0, random_seed} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      random_seed <= SEED_RESET;
    end else if (seed_we) begin
      random_seed <= pwdata[15:0];
    end
  end

  // Take requests whenever the controller is idle.
  assign req.ready = ctrl_in_ready;

  fsg_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(ctrl_in_ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts(sts), .cmd(cmd)
  );

  fsg_datapath #(.GRID_W(GRID_W), .GRID_H(GRID_H), .MAX_RADIUS(MAX_RADIUS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_action(req.data[20:19]), .in_x(req.data[18:13]), .in_y(req.data[12:7]),
    .in_r(req.data[6:3]), .in_kind(req.data[2:0]),
    .seed_we(seed_we), .seed_val(pwdata[15:0]),
    .read_kind(read_kind)
  );

  assign rsp.data = read_kind;
endmodule

// ===== dv/tb_top.sv =====
// Testbench for falling_sand_grid_step: directed table then random requests.
// It predicts each untyped response from its own grid, marks and LFSR copy.
// Depends on fsg_pkg, fsg_if and the block RTL.
module tb_top;
  import fsg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GW = DEF_GRID_W;
  localparam int GH = DEF_GRID_H;
  localparam int REQ_W = 21;
  localparam int LIMIT_CYCLES = 6_000_000;
  localparam logic [1:0] SEED_ADDR = 2'(4 * REG_RANDOM_SEED);

  typedef struct {
    action_t     act;
    logic [5:0]  x;
    logic [5:0]  y;
    logic [3:0]  rad;
    logic [2:0]  kind;
    bit          typed;  // response value written into the table
    logic [2:0]  want;
  } sand_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fsg_if #(.W(REQ_W)) req_if (clk);
  fsg_if #(.W(3))     rsp_if (clk);

  falling_sand_grid_step u_dut (
    .clk(clk), .rst(rst), .req(req_if), .rsp(rsp_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Predicted grid state.
  logic [2:0]  grid_kind [GW*GH];
  bit          grid_mark [GW*GH];
  logic [15:0] side_lfsr;

  logic [2:0] expected_kinds[$];
  int  mismatches = 0;
  int  responses = 0;
  bit  quiet = 1'b0;       // no idling on either side
  bit  held_once = 1'b0;   // long receiver hold-off already done

  function automatic int weight_of(input logic [2:0] k);
    case (k)
      KIND_SAND, KIND_DIRT: return 2;
      KIND_WATER:           return 1;
      KIND_STONE:           return 3;
      default:              return 0;
    endcase
  endfunction

  function automatic bit on_grid(input int x, input int y);
    return x >= 0 && x < GW && y >= 0 && y < GH;
  endfunction

  function automatic bit can_sink(input int x0, input int y0, input int x1, input int y1);
    if (!on_grid(x0, y0) || !on_grid(x1, y1)) return 1'b0;
    return weight_of(grid_kind[y1*GW+x1]) < weight_of(grid_kind[y0*GW+x0]);
  endfunction

  // Galois LFSR, right shift; the old bit 0 picks the side.
  function automatic bit side_pick();
    bit b;
    b = side_lfsr[0];
    side_lfsr = side_lfsr >> 1;
    if (b) side_lfsr = side_lfsr ^ LFSR_TAPS;
    return b;
  endfunction

  function automatic void tick_grid();
    int tx, ty, here, there;
    bit moved, falls, flows;
    logic [2:0] k, t;
    foreach (grid_mark[i]) grid_mark[i] = 1'b0;
    for (int y = 0; y < GH; y++) begin
      for (int x = 0; x < GW; x++) begin
        here = y*GW + x;
        if (grid_mark[here]) continue;
        k = grid_kind[here];
        falls = (k == KIND_SAND) || (k == KIND_WATER) || (k == KIND_DIRT);
        flows = (k == KIND_WATER);
        tx = x; ty = y; moved = 1'b0;
        if (falls) begin
          if (can_sink(x, y, x, y+1)) begin
            ty = y + 1; moved = 1'b1;
          end else if (can_sink(x, y, x-1, y+1)) begin
            ty = y + 1;
            tx = (can_sink(x, y, x+1, y+1) && side_pick()) ? x + 1 : x - 1;
            moved = 1'b1;
          end else if (can_sink(x, y, x+1, y+1)) begin
            ty = y + 1; tx = x + 1; moved = 1'b1;
          end
        end
        if (!moved && flows) begin
          if (can_sink(x, y, x+1, y)) begin
            tx = (can_sink(x, y, x-1, y) && side_pick()) ? x - 1 : x + 1;
            moved = 1'b1;
          end else if (can_sink(x, y, x-1, y)) begin
            tx = x - 1; moved = 1'b1;
          end
        end
        grid_mark[here] = 1'b1;
        if (moved) begin
          there = ty*GW + tx;
          t = grid_kind[here];
          grid_kind[here] = grid_kind[there];
          grid_kind[there] = t;
          grid_mark[there] = 1'b1;
        end
      end
    end
  endfunction

  // Apply one request to the predicted grid, return the expected read_kind.
  function automatic logic [2:0] grid_apply(input sand_req_t r);
    logic [2:0] k;
    int rr;
    k = (r.kind <= KIND_DIRT) ? r.kind : KIND_EMPTY;
    case (r.act)
      ACT_SET: grid_kind[r.y*GW + r.x] = k;
      ACT_DISC: begin
        rr = (r.rad > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : r.rad;
        for (int dy = -rr; dy <= rr; dy++)
          for (int dx = -rr; dx <= rr; dx++)
            if (dx*dx + dy*dy <= rr*rr && on_grid(int'(r.x) + dx, int'(r.y) + dy))
              grid_kind[(int'(r.y) + dy)*GW + int'(r.x) + dx] = k;
      end
      ACT_READ: return grid_kind[r.y*GW + r.x];
      default: tick_grid();
    endcase
    return KIND_EMPTY;
  endfunction

  function automatic sand_req_t mk(input action_t a, input int x, input int y,
                                   input int rad, input int kind,
                                   input bit typed = 1'b0, input int want = 0);
    sand_req_t r;
    r.act = a; r.x = 6'(x); r.y = 6'(y); r.rad = 4'(rad); r.kind = 3'(kind);
    r.typed = typed; r.want = 3'(want);
    return r;
  endfunction

  // Offer one request; once accepted, predict and queue its response.
  task automatic offer(input sand_req_t r);
    logic [2:0] predicted;
    if (!quiet && $urandom_range(3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= {r.act, r.x, r.y, r.rad, r.kind};
    do @(negedge clk); while (!req_if.ready);
    @(posedge clk);
    predicted = grid_apply(r);
    expected_kinds.push_back(r.typed ? r.want : predicted);
  endtask

  // Random requests: mostly sand/water/dirt poured and stepped, with reads.
  task automatic pour_random(input int count);
    sand_req_t r;
    int pick, k;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      k = $urandom_range(99);
      k = (k < 70) ? (k % 3 == 0 ? KIND_SAND : (k % 3 == 1 ? KIND_WATER : KIND_DIRT))
                   : $urandom_range(7);
      if (pick < 13)
        r = mk(ACT_TICK, $urandom_range(63), $urandom_range(63), $urandom_range(15),
               $urandom_range(7));
      else if (pick < 33)
        r = mk(ACT_DISC, $urandom_range(63), $urandom_range(40),
               ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(4), k);
      else if (pick < 58)
        r = mk(ACT_SET, $urandom_range(63), $urandom_range(63), $urandom_range(15), k);
      else
        r = mk(ACT_READ, $urandom_range(63), $urandom_range(63), $urandom_range(15),
               $urandom_range(7));
      offer(r);
    end
  endtask

  // Write the seed while the block is idle; the LFSR copy reloads too.
  task automatic write_seed(input logic [15:0] seed);
    req_if.valid <= 1'b0;
    wait (expected_kinds.size() == 0);
    @(posedge clk);
    req_if.valid <= 1'b0;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= SEED_ADDR; pwdata <= {16'h0, seed};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    side_lfsr = (seed == 16'h0) ? 16'h1 : seed;
  endtask

  // Directed table: corners, every non-empty kind incl. out-of-range, radius
  // extremes, disc off the corner, a plain fall and a sideways water choice.
  sand_req_t plan[$];

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    foreach (grid_kind[i]) grid_kind[i] = KIND_EMPTY;
    side_lfsr = SEED_RESET;
    plan = '{
      mk(ACT_READ, 0, 0, 0, 0, 1, KIND_EMPTY),
      mk(ACT_SET, 0, 0, 0, KIND_SAND, 1, 0),
      mk(ACT_READ, 0, 0, 0, 0, 1, KIND_SAND),
      mk(ACT_SET, 63, 63, 15, KIND_DIRT, 1, 0),
      mk(ACT_READ, 63, 63, 0, 7, 1, KIND_DIRT),
      mk(ACT_SET, 5, 5, 0, 7, 1, 0),
      mk(ACT_READ, 5, 5, 0, 0, 1, KIND_EMPTY),
      mk(ACT_SET, 63, 0, 0, 6, 1, 0),
      mk(ACT_READ, 63, 0, 0, 0, 1, KIND_EMPTY),
      mk(ACT_DISC, 10, 10, 0, KIND_WATER, 1, 0),
      mk(ACT_READ, 10, 10, 0, 0, 1, KIND_WATER),
      mk(ACT_DISC, 0, 0, 15, KIND_STONE, 1, 0),
      mk(ACT_READ, 15, 0, 0, 0, 1, KIND_STONE),
      mk(ACT_READ, 10, 10, 0, 0, 1, KIND_STONE),
      mk(ACT_DISC, 63, 63, 15, KIND_GAS, 1, 0),
      mk(ACT_READ, 63, 63, 0, 0, 1, KIND_GAS),
      mk(ACT_SET, 32, 10, 0, KIND_SAND, 1, 0),
      mk(ACT_SET, 50, 63, 0, KIND_WATER, 1, 0),
      mk(ACT_TICK, 0, 0, 0, 0, 1, 0),
      mk(ACT_READ, 32, 11, 0, 0, 1, KIND_SAND),
      mk(ACT_READ, 49, 63, 0, 0),
      mk(ACT_READ, 51, 63, 0, 0),
      mk(ACT_READ, 63, 62, 0, 0)
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset seed first, then zero seed, all-ones seed and a random one.
    foreach (plan[i]) offer(plan[i]);
    write_seed(16'h0000);
    pour_random(30);
    write_seed(16'hFFFF);
    pour_random(25);
    write_seed(16'($urandom_range(2, 65534)));
    quiet = 1'b1;
    pour_random(22);

    @(posedge clk);
    req_if.valid <= 1'b0;
    wait (expected_kinds.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  // Response side: random stalls, one long hold-off to back the block up.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && responses == 45) begin
        held_once = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (stall_left == 0 && !quiet && $urandom_range(4) == 0)
        stall_left = $urandom_range(1, 6);
      if (stall_left > 0 && !quiet) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        stall_left = 0;
        rsp_if.ready <= 1'b1;
      end
      @(negedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        responses++;
        if (expected_kinds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response read_kind=%0d", rsp_if.data);
        end else begin
          logic [2:0] want;
          want = expected_kinds.pop_front();
          if (rsp_if.data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response %0d: read_kind expected %0d, got %0d",
                       responses, want, rsp_if.data);
          end
        end
      end
    end
  end

  // Watchdog: drop the run if it never drains.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
